>>> sv/vkdi_pkg.sv
package vkdi_pkg;

    localparam int TABLE_SLOTS  = 8192;
    localparam int MAX_VERTICES = 4096;
    localparam int COMPACT_W    = 12;
    localparam int EPOCH_W      = 4;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    localparam logic [1:0] STATUS_SEEN = 2'd0;
    localparam logic [1:0] STATUS_NEW  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] vertex_key;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic        start_mesh;
    } in_t;

    typedef struct packed {
        logic [COMPACT_W-1:0] compact_index;
        logic [1:0]           status;
        logic [31:0]          new_x;
        logic [31:0]          new_y;
        logic [31:0]          new_z;
    } out_t;

endpackage

>>> sv/vertex_key_dedup_indexer.sv
// Channel | Direction | Handshake        | Payload
// s_      | in        | s_valid, s_ready | vkdi_pkg::in_t  (key, x, y, z, start_mesh)
// m_      | out       | m_valid, m_ready | vkdi_pkg::out_t (index, status, x, y, z)
//
// A request probes P slots, one slot per cycle from the slot memory; a table size
// that is not a power of two adds the ST_MOD, ST_QUO and ST_REM states for the
// reciprocal home slot reduction.
// After reset the slot memory is swept, one slot per cycle, before s_ready rises;
// every fifteenth start_mesh request runs the same sweep.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted. A stalled m_ready holds the probe.
module vertex_key_dedup_indexer #(
    parameter int TABLE_SLOTS  = vkdi_pkg::TABLE_SLOTS,
    parameter int MAX_VERTICES = vkdi_pkg::MAX_VERTICES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vkdi_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output vkdi_pkg::out_t m_data
);

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int IDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int PRB_W   = $clog2(TABLE_SLOTS + 1);
    localparam int EP_W    = vkdi_pkg::EPOCH_W;
    localparam int CW      = vkdi_pkg::COMPACT_W;
    localparam int WORD_W  = EP_W + 32 + IDX_W;
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

    // reciprocal for x mod TABLE_SLOTS: q = (t + ((x - t) >> 1)) >> (SLOT_W - 1)
    localparam logic [63:0] MAGIC_W =
        (((64'd1 << SLOT_W) - 64'(TABLE_SLOTS)) << 32) / 64'(TABLE_SLOTS) + 64'd1;
    localparam logic [31:0] MAGIC = MAGIC_W[31:0];

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] N_LOW     = SLOT_W'(TABLE_SLOTS);
    localparam logic [PRB_W-1:0]  LAST_PRB  = PRB_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_VERTICES);
    localparam logic [EP_W-1:0]   EP_LAST   = {EP_W{1'b1}};
    localparam logic [EP_W-1:0]   EP_FIRST  = EP_W'(1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_SEEK  = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_QUO   = 3'd5;
    localparam logic [2:0] ST_REM   = 3'd6;

    localparam logic [2:0] ST_HOME = IS_POW2 ? ST_SEEK : ST_MOD;

    logic [2:0]        state_reg, state_next;
    vkdi_pkg::in_t     item_reg, item_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       mul_hi_reg, mul_hi_next;
    logic [31:0]       quo_reg, quo_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_item_reg, clr_item_next;
    logic [EP_W-1:0]   epoch_reg, epoch_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] chk_slot_reg, chk_slot_next;
    logic [PRB_W-1:0]  probes_reg, probes_next;
    logic              m_valid_reg, m_valid_next;
    vkdi_pkg::out_t    m_data_reg, m_data_next;

    logic [WORD_W-1:0] mem [TABLE_SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    logic [EP_W-1:0]   rd_tag;
    logic [31:0]       rd_key;
    logic [IDX_W-1:0]  rd_idx;
    logic              slot_empty;
    logic              slot_hit;
    logic              out_free;
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] next_slot;
    logic [63:0]       mag_prod;
    logic [SLOT_W-1:0] quo_n;

    assign {rd_tag, rd_key, rd_idx} = rd_data_reg;
    assign slot_empty = rd_tag != epoch_reg;
    assign slot_hit   = !slot_empty && (rd_key == item_reg.vertex_key);
    assign out_free   = !m_valid_reg || m_ready;
    assign home       = IS_POW2 ? prod_reg[SLOT_W-1:0] : rem_reg;
    assign next_slot  = (chk_slot_reg == LAST_SLOT) ? '0 : chk_slot_reg + 1'b1;
    assign mag_prod   = 64'(prod_reg) * 64'(MAGIC);
    assign quo_n      = quo_reg[SLOT_W-1:0] * N_LOW;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        prod_next     = prod_reg;
        mul_hi_next   = mul_hi_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        epoch_next    = epoch_reg;
        count_next    = count_reg;
        chk_slot_next = chk_slot_reg;
        probes_next   = probes_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        rd_addr       = chk_slot_reg;
        we            = 1'b0;
        wr_addr       = chk_slot_reg;
        wr_data       = {epoch_reg, item_reg.vertex_key, count_reg[IDX_W-1:0]};
        case (state_reg)
            ST_CLEAR: begin
                we      = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == LAST_SLOT) begin
                    epoch_next    = EP_FIRST;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_HOME : ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    prod_next = 32'(s_data.vertex_key * vkdi_pkg::HASH_MUL);
                    state_next = ST_HOME;
                    if (s_data.start_mesh) begin
                        count_next = '0;
                        if (epoch_reg == EP_LAST) begin
                            clr_item_next = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            ST_MOD: begin
                mul_hi_next = mag_prod[63:32];
                state_next  = ST_QUO;
            end
            ST_QUO: begin
                quo_next   = (mul_hi_reg + ((prod_reg - mul_hi_reg) >> 1)) >> (SLOT_W - 1);
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = prod_reg[SLOT_W-1:0] - quo_n;
                state_next = ST_SEEK;
            end
            ST_SEEK: begin
                rd_addr       = home;
                chk_slot_next = home;
                probes_next   = '0;
                state_next    = ST_PROBE;
            end
            ST_PROBE: begin
                if (slot_empty || slot_hit || probes_reg == LAST_PRB) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        state_next   = ST_IDLE;
                        if (slot_hit) begin
                            m_data_next.compact_index = CW'(rd_idx);
                            m_data_next.status        = vkdi_pkg::STATUS_SEEN;
                        end else if (slot_empty && count_reg < CNT_LIMIT) begin
                            we         = 1'b1;
                            count_next = count_reg + 1'b1;
                            m_data_next.compact_index = CW'(count_reg);
                            m_data_next.status        = vkdi_pkg::STATUS_NEW;
                            m_data_next.new_x         = item_reg.pos_x;
                            m_data_next.new_y         = item_reg.pos_y;
                            m_data_next.new_z         = item_reg.pos_z;
                        end else begin
                            m_data_next.status = vkdi_pkg::STATUS_FULL;
                        end
                    end
                end else begin
                    chk_slot_next = next_slot;
                    rd_addr       = next_slot;
                    probes_next   = probes_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            epoch_reg    <= '0;
            count_reg    <= '0;
            probes_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            epoch_reg    <= epoch_next;
            count_reg    <= count_next;
            probes_reg   <= probes_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        mul_hi_reg   <= mul_hi_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        chk_slot_reg <= chk_slot_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    a_epoch_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> (epoch_reg != '0))
        else $error("table epoch is zero outside the clearing sweep");

    a_insert_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && we) |-> (count_reg < CNT_LIMIT))
        else $error("slot written beyond the vertex limit");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && we) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("vertex count did not advance on insert");

    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (probes_reg <= LAST_PRB))
        else $error("probe ran past the table size");
`endif

endmodule

>>> tb/vertex_key_dedup_indexer_tb.sv
`timescale 1ns / 1ps

module vertex_key_dedup_indexer_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        vkdi_pkg::in_t  req;
        logic           typed;
        vkdi_pkg::out_t want;
    } vec_t;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    vkdi_pkg::in_t  s_data;
    logic           m_valid;
    logic           m_ready;
    vkdi_pkg::out_t m_data;

    vertex_key_dedup_indexer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // shadow hash table
    bit          slot_used [vkdi_pkg::TABLE_SLOTS];
    logic [31:0] slot_tag  [vkdi_pkg::TABLE_SLOTS];
    logic [11:0] slot_idx  [vkdi_pkg::TABLE_SLOTS];
    int unsigned verts;

    vkdi_pkg::out_t expected_q [$];
    vec_t           directed [$];
    vkdi_pkg::out_t want;

    int src_idle_pct;
    int dst_idle_pct;
    int errors;
    int cycles;
    int requests_sent;
    int results_seen;
    int mesh_starts;
    int status_tally [3];

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= dst_idle_pct);

    function automatic vkdi_pkg::in_t make_request(logic [31:0] key, logic [31:0] x,
                                                   logic [31:0] y, logic [31:0] z,
                                                   logic start);
        vkdi_pkg::in_t r;
        r.vertex_key = key;
        r.pos_x      = x;
        r.pos_y      = y;
        r.pos_z      = z;
        r.start_mesh = start;
        return r;
    endfunction

    function automatic vkdi_pkg::out_t make_result(logic [11:0] idx, logic [1:0] st,
                                                   logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        vkdi_pkg::out_t r;
        r.compact_index = idx;
        r.status        = st;
        r.new_x         = x;
        r.new_y         = y;
        r.new_z         = z;
        return r;
    endfunction

    function automatic vkdi_pkg::out_t lookup_vertex(vkdi_pkg::in_t req);
        vkdi_pkg::out_t res;
        logic [31:0]    prod;
        int unsigned    slot;
        int unsigned    n;
        bit             hit;
        bit             hole;
        res  = '0;
        hit  = 1'b0;
        hole = 1'b0;
        if (req.start_mesh) begin
            for (int i = 0; i < vkdi_pkg::TABLE_SLOTS; i++) slot_used[i] = 1'b0;
            verts = 0;
        end
        prod = req.vertex_key * vkdi_pkg::HASH_MUL;
        slot = prod % vkdi_pkg::TABLE_SLOTS;
        n    = 0;
        while (!hit && !hole && n < vkdi_pkg::TABLE_SLOTS) begin
            if (!slot_used[slot]) begin
                hole = 1'b1;
            end else if (slot_tag[slot] == req.vertex_key) begin
                hit = 1'b1;
            end else begin
                slot = (slot + 1) % vkdi_pkg::TABLE_SLOTS;
                n++;
            end
        end
        if (hit) begin
            res.compact_index = slot_idx[slot];
            res.status        = vkdi_pkg::STATUS_SEEN;
        end else if (hole && verts < vkdi_pkg::MAX_VERTICES) begin
            slot_used[slot]   = 1'b1;
            slot_tag[slot]    = req.vertex_key;
            slot_idx[slot]    = vkdi_pkg::COMPACT_W'(verts);
            res.compact_index = vkdi_pkg::COMPACT_W'(verts);
            res.status        = vkdi_pkg::STATUS_NEW;
            res.new_x         = req.pos_x;
            res.new_y         = req.pos_y;
            res.new_z         = req.pos_z;
            verts++;
        end else begin
            res.status = vkdi_pkg::STATUS_FULL;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch at result %0d: %s got %h want %h",
                 results_seen, what, got, exp_val);
        errors++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input vkdi_pkg::in_t req, input logic typed,
                                input vkdi_pkg::out_t typed_res);
        vkdi_pkg::out_t pred;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = lookup_vertex(req);
        expected_q.push_back(typed ? typed_res : pred);
        status_tally[pred.status]++;
        requests_sent++;
        if (req.start_mesh) mesh_starts++;
        @(negedge aclk);
    endtask

    task automatic add_row(input vkdi_pkg::in_t req, input logic typed,
                           input vkdi_pkg::out_t res);
        vec_t v;
        v.req   = req;
        v.typed = typed;
        v.want  = res;
        directed.push_back(v);
    endtask

    task automatic random_request(input logic [31:0] key, input logic start);
        send_request(make_request(key, $urandom, $urandom, $urandom, start), 1'b0, '0);
    endtask

    task automatic run_meshes(input int n_items);
        int          sent;
        int          len;
        int          pick;
        logic        start;
        logic [31:0] key;
        logic [31:0] chain_base;
        logic [31:0] mesh_keys [$];
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 120) : $urandom_range(60, 1);
            chain_base = $urandom;
            mesh_keys.delete();
            for (int i = 0; i < len && sent < n_items; i++) begin
                // stray start inside a mesh now and then
                start = (i == 0) || ($urandom_range(99) == 0);
                if (start) mesh_keys.delete();
                pick = $urandom_range(99);
                if (mesh_keys.size() != 0 && pick < 35)
                    key = mesh_keys[$urandom_range(mesh_keys.size() - 1)];
                else if (pick < 45)
                    key = chain_base + ($urandom_range(15) << 13);
                else
                    key = $urandom;
                mesh_keys.push_back(key);
                random_request(key, start);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected, index",
                                32'(m_data.compact_index), 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_data.compact_index !== want.compact_index)
                    report_mismatch("compact_index", 32'(m_data.compact_index),
                                    32'(want.compact_index));
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                if (m_data.new_x !== want.new_x)
                    report_mismatch("new_x", m_data.new_x, want.new_x);
                if (m_data.new_y !== want.new_y)
                    report_mismatch("new_y", m_data.new_y, want.new_y);
                if (m_data.new_z !== want.new_z)
                    report_mismatch("new_z", m_data.new_z, want.new_z);
            end
            results_seen++;
        end
    end

    initial begin : main_seq
        logic [31:0] wrap_key;
        logic [31:0] prod;
        vec_t        row;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        errors        = 0;
        cycles        = 0;
        requests_sent = 0;
        results_seen  = 0;
        mesh_starts   = 0;
        verts         = 0;
        for (int i = 0; i < 3; i++) status_tally[i] = 0;
        for (int i = 0; i < vkdi_pkg::TABLE_SLOTS; i++) slot_used[i] = 1'b0;
        src_idle_pct = 15;
        dst_idle_pct = 47;

        // key whose home is the last slot, so its chain wraps to slot 0
        wrap_key = 0;
        for (int k = 0; k < vkdi_pkg::TABLE_SLOTS; k++) begin
            prod = 32'(k) * vkdi_pkg::HASH_MUL;
            if (prod % vkdi_pkg::TABLE_SLOTS == vkdi_pkg::TABLE_SLOTS - 1)
                wrap_key = 32'(k);
        end

        add_row(make_request(32'h0, 32'h0, 32'h0, 32'h0, 1'b0), 1'b1,
                make_result(12'd0, vkdi_pkg::STATUS_NEW, 32'h0, 32'h0, 32'h0));
        add_row(make_request('1, '1, '1, '1, 1'b0), 1'b1,
                make_result(12'd1, vkdi_pkg::STATUS_NEW, '1, '1, '1));
        add_row(make_request(32'h0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0), 1'b1,
                make_result(12'd0, vkdi_pkg::STATUS_SEEN, 32'h0, 32'h0, 32'h0));
        add_row(make_request('1, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0), 1'b1,
                make_result(12'd1, vkdi_pkg::STATUS_SEEN, 32'h0, 32'h0, 32'h0));
        add_row(make_request(32'h12345678, 32'h3f800000, 32'hbf800000, 32'h7f800000, 1'b1),
                1'b1, make_result(12'd0, vkdi_pkg::STATUS_NEW, 32'h3f800000, 32'hbf800000,
                                  32'h7f800000));
        add_row(make_request(32'h0, 32'h80000000, 32'h7fc00000, 32'h00000001, 1'b0), 1'b1,
                make_result(12'd1, vkdi_pkg::STATUS_NEW, 32'h80000000, 32'h7fc00000,
                            32'h00000001));
        for (int i = 0; i < 6; i++)
            add_row(make_request(wrap_key + (32'(i) << 13), $urandom, $urandom, $urandom,
                                 1'b0), 1'b0, '0);
        add_row(make_request(wrap_key + (32'd5 << 13), $urandom, $urandom, $urandom, 1'b0),
                1'b0, '0);
        add_row(make_request(wrap_key, $urandom, $urandom, $urandom, 1'b0), 1'b0, '0);
        add_row(make_request(32'h0, 32'h00800000, 32'h7f7fffff, 32'hff800000, 1'b1), 1'b1,
                make_result(12'd0, vkdi_pkg::STATUS_NEW, 32'h00800000, 32'h7f7fffff,
                            32'hff800000));
        add_row(make_request(32'h0, 32'h00000001, 32'h80000001, 32'hfffffffe, 1'b1), 1'b1,
                make_result(12'd0, vkdi_pkg::STATUS_NEW, 32'h00000001, 32'h80000001,
                            32'hfffffffe));
        add_row(make_request('1, $urandom, $urandom, $urandom, 1'b0), 1'b0, '0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < directed.size(); r++) begin
            row = directed[r];
            send_request(row.req, row.typed, row.want);
        end
        run_meshes(470);

        src_idle_pct = 47;
        dst_idle_pct = 15;
        run_meshes(470);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_meshes(430);
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests over %0d mesh starts: %0d new, %0d repeated, %0d full",
                 requests_sent, mesh_starts, status_tally[vkdi_pkg::STATUS_NEW],
                 status_tally[vkdi_pkg::STATUS_SEEN], status_tally[vkdi_pkg::STATUS_FULL]);
        $display("%0d results checked, %0d mismatches, %0d cycles",
                 results_seen, errors, cycles);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
sv/vkdi_pkg.sv
sv/vertex_key_dedup_indexer.sv
tb/vertex_key_dedup_indexer_tb.sv
